[sv/binary_to_bcd_with_rounding_assert.svh]
// Assertion macros for the binary to BCD converter.
// Needs aclk and aresetn in the scope of each use.
`ifndef BINARY_TO_BCD_WITH_ROUNDING_ASSERT_SVH
`define BINARY_TO_BCD_WITH_ROUNDING_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define B2B_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define B2B_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/b2bcdr_pkg.sv]
// Types and constants for the binary to BCD converter with rounding.
// No dependencies.
`default_nettype none

package b2bcdr_pkg;

    localparam int ValueW       = 64;
    localparam int NumDigits    = 20;
    localparam int DigitW       = 4;
    localparam int BcdW         = NumDigits * DigitW;
    localparam int CountW       = 5;
    localparam int DabStages    = 8;
    localparam int BitsPerStage = ValueW / DabStages;
    localparam int RndStage     = DabStages + 1;
    localparam int IncStage     = DabStages + 2;
    localparam int OutStage     = DabStages + 3;
    localparam int NumStages    = DabStages + 4;
    localparam int SDataW       = 72;
    localparam int MDataW       = 96;
    localparam int SUserW       = 1;
    localparam int MUserW       = 2;

    typedef logic [ValueW-1:0] value_t;
    typedef logic [BcdW-1:0]   bcd_t;
    typedef logic [DigitW-1:0] digit_t;
    typedef logic [CountW-1:0] count_t;

endpackage

`default_nettype wire

[sv/binary_to_bcd_with_rounding.sv]
// Binary to packed BCD converter with half-up decimal rounding; uses b2bcdr_pkg.
// Pipeline: input word to result word through 12 register stages
// (magnitude, eight shift-add-3 stages of 8 bits each, round select, increment, count).
// Throughput: one word per cycle; each stage holds under back-pressure and fills bubbles.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
`default_nettype none

`include "binary_to_bcd_with_rounding_assert.svh"

module binary_to_bcd_with_rounding (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // value [63:0], round_drop [68:64], zero [71:69]
    input  wire logic [b2bcdr_pkg::SDataW-1:0]  s_tdata,
    // is_signed [0]
    input  wire logic [b2bcdr_pkg::SUserW-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // bcd_low [63:0], bcd_high [79:64], digit_count [84:80],
    // trailing_zeros [89:85], zero [95:90]
    output logic [b2bcdr_pkg::MDataW-1:0]       m_tdata,
    // negative [0], length_grew [1]
    output logic [b2bcdr_pkg::MUserW-1:0]       m_tuser
);

    localparam int NS  = b2bcdr_pkg::NumStages;
    localparam int DS  = b2bcdr_pkg::DabStages;
    localparam int ND  = b2bcdr_pkg::NumDigits;
    localparam int DW  = b2bcdr_pkg::DigitW;
    localparam int VW  = b2bcdr_pkg::ValueW;
    localparam int BPS = b2bcdr_pkg::BitsPerStage;
    localparam int RS  = b2bcdr_pkg::RndStage;
    localparam int IS  = b2bcdr_pkg::IncStage;
    localparam int OS  = b2bcdr_pkg::OutStage;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] rdy;

    b2bcdr_pkg::value_t in_value;
    b2bcdr_pkg::count_t in_drop;
    logic               in_neg;

    b2bcdr_pkg::value_t bin_reg  [0:DS-1];
    b2bcdr_pkg::bcd_t   bcd_reg  [1:DS];
    logic               neg_reg  [0:DS];
    b2bcdr_pkg::count_t drop_reg [0:DS];
    b2bcdr_pkg::bcd_t   dab_next [1:DS];

    b2bcdr_pkg::bcd_t   rnd_bcd_next;
    b2bcdr_pkg::count_t rnd_len_next;
    logic               rnd_up_next;
    logic               rnd_ok_next;
    b2bcdr_pkg::bcd_t   rnd_bcd_reg;
    b2bcdr_pkg::count_t rnd_len_reg;
    b2bcdr_pkg::count_t rnd_drop_reg;
    logic               rnd_up_reg;
    logic               rnd_ok_reg;
    logic               rnd_neg_reg;

    b2bcdr_pkg::bcd_t   inc_bcd_next;
    b2bcdr_pkg::bcd_t   inc_bcd_reg;
    b2bcdr_pkg::count_t inc_len_reg;
    logic               inc_ok_reg;
    logic               inc_neg_reg;

    b2bcdr_pkg::count_t out_len_next;
    b2bcdr_pkg::count_t out_tz_next;
    b2bcdr_pkg::bcd_t   out_bcd_reg;
    b2bcdr_pkg::count_t out_len_reg;
    b2bcdr_pkg::count_t out_tz_reg;
    logic               out_neg_reg;
    logic               out_grew_reg;

    // handshake: a stage takes a word when it is empty or its successor takes its word
    assign rdy[NS-1] = !valid_reg[NS-1] || m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_comb begin
        valid_next = valid_reg;
        if (rdy[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign in_value = s_tdata[VW-1:0];
    assign in_drop  = s_tdata[VW +: b2bcdr_pkg::CountW];
    assign in_neg   = s_tuser[0] && s_tdata[VW-1];

    // shift-add-3, BPS bits per stage
    always_comb begin
        b2bcdr_pkg::bcd_t   acc;
        b2bcdr_pkg::value_t bin;
        for (int k = 1; k <= DS; k++) begin
            acc = (k == 1) ? '0 : bcd_reg[(k == 1) ? 1 : k-1];
            bin = bin_reg[k-1];
            for (int s = 0; s < BPS; s++) begin
                for (int d = 0; d < ND; d++) begin
                    if (acc[d*DW +: DW] >= DW'(5)) begin
                        acc[d*DW +: DW] = DW'(acc[d*DW +: DW] + DW'(3));
                    end
                end
                acc = {acc[b2bcdr_pkg::BcdW-2:0], bin[VW-1]};
                bin = {bin[VW-2:0], 1'b0};
            end
            dab_next[k] = acc;
        end
    end

    // length, round digit, clear dropped digits
    always_comb begin
        b2bcdr_pkg::digit_t rdig;
        b2bcdr_pkg::count_t len0;
        logic               zap;
        len0 = '0;
        rdig = '0;
        for (int i = 0; i < ND; i++) begin
            if (bcd_reg[DS][i*DW +: DW] != '0) begin
                len0 = b2bcdr_pkg::CountW'(i + 1);
            end
            if (drop_reg[DS] == b2bcdr_pkg::CountW'(i + 1)) begin
                rdig = bcd_reg[DS][i*DW +: DW];
            end
        end
        rnd_ok_next  = (drop_reg[DS] != '0) && (drop_reg[DS] <= len0);
        zap          = (drop_reg[DS] != '0) && (drop_reg[DS] > len0);
        rnd_up_next  = rnd_ok_next && (rdig >= DW'(5));
        rnd_len_next = len0;
        rnd_bcd_next = bcd_reg[DS];
        for (int i = 0; i < ND; i++) begin
            if (zap || (b2bcdr_pkg::CountW'(i) < drop_reg[DS])) begin
                rnd_bcd_next[i*DW +: DW] = '0;
            end
        end
    end

    // add one at the drop position, carry through runs of nines
    always_comb begin
        logic [ND-1:0] nine;
        logic          carry;
        for (int i = 0; i < ND; i++) begin
            nine[i] = (rnd_bcd_reg[i*DW +: DW] == DW'(9));
        end
        inc_bcd_next = rnd_bcd_reg;
        for (int i = 0; i < ND; i++) begin
            carry = rnd_up_reg && (b2bcdr_pkg::CountW'(i) >= rnd_drop_reg);
            for (int j = 0; j < i; j++) begin
                if ((b2bcdr_pkg::CountW'(j) >= rnd_drop_reg) && !nine[j]) begin
                    carry = 1'b0;
                end
            end
            if (carry) begin
                inc_bcd_next[i*DW +: DW] = nine[i] ? '0
                                         : DW'(rnd_bcd_reg[i*DW +: DW] + DW'(1));
            end
        end
    end

    // digit count and trailing zeros of the result
    always_comb begin
        out_len_next = '0;
        out_tz_next  = '0;
        for (int i = 0; i < ND; i++) begin
            if (inc_bcd_reg[i*DW +: DW] != '0) begin
                out_len_next = b2bcdr_pkg::CountW'(i + 1);
            end
        end
        for (int i = ND - 1; i >= 0; i--) begin
            if (inc_bcd_reg[i*DW +: DW] != '0) begin
                out_tz_next = b2bcdr_pkg::CountW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            bin_reg[0]  <= in_neg ? VW'(-in_value) : in_value;
            neg_reg[0]  <= in_neg;
            drop_reg[0] <= in_drop;
        end
        for (int k = 1; k <= DS; k++) begin
            if (rdy[k]) begin
                bcd_reg[k]  <= dab_next[k];
                neg_reg[k]  <= neg_reg[k-1];
                drop_reg[k] <= drop_reg[k-1];
            end
        end
        for (int k = 1; k < DS; k++) begin
            if (rdy[k]) begin
                bin_reg[k] <= bin_reg[k-1] << BPS;
            end
        end
        if (rdy[RS]) begin
            rnd_bcd_reg  <= rnd_bcd_next;
            rnd_len_reg  <= rnd_len_next;
            rnd_drop_reg <= drop_reg[DS];
            rnd_up_reg   <= rnd_up_next;
            rnd_ok_reg   <= rnd_ok_next;
            rnd_neg_reg  <= neg_reg[DS];
        end
        if (rdy[IS]) begin
            inc_bcd_reg <= inc_bcd_next;
            inc_len_reg <= rnd_len_reg;
            inc_ok_reg  <= rnd_ok_reg;
            inc_neg_reg <= rnd_neg_reg;
        end
        if (rdy[OS]) begin
            out_bcd_reg  <= inc_bcd_reg;
            out_len_reg  <= out_len_next;
            out_tz_reg   <= out_tz_next;
            out_neg_reg  <= inc_neg_reg && (out_len_next != '0);
            out_grew_reg <= inc_ok_reg && (out_len_next > inc_len_reg);
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {(b2bcdr_pkg::MDataW - b2bcdr_pkg::BcdW - 2*b2bcdr_pkg::CountW)'(0),
                       out_tz_reg, out_len_reg, out_bcd_reg};
    assign m_tuser  = {out_grew_reg, out_neg_reg};

    `B2B_ASSERT_NXT(a_accept_fills_first, s_tvalid && s_tready, valid_reg[0],
        "accepted word did not enter the first stage")
    `B2B_ASSERT_IMP(a_neg_nonzero, m_tvalid && out_neg_reg, out_len_reg != '0,
        "negative flag on a zero result")
    `B2B_ASSERT_IMP(a_zero_clean, m_tvalid && (out_len_reg == '0),
        (out_bcd_reg == '0) && (out_tz_reg == '0), "zero result with digits or trailing zeros")
    `B2B_ASSERT_IMP(a_grew_power, m_tvalid && out_grew_reg,
        out_tz_reg == b2bcdr_pkg::CountW'(out_len_reg - 5'd1),
        "grown result is not a power of ten")

endmodule

`default_nettype wire

[verif/binary_to_bcd_with_rounding_tb.sv]
// Self-checking testbench for binary_to_bcd_with_rounding: drives converter words with
// random idling and stalls, predicts each rounded BCD word and compares in order.
// Depends on b2bcdr_pkg and the binary_to_bcd_with_rounding RTL.
`default_nettype none

module binary_to_bcd_with_rounding_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0]        bcd_low;
        logic [15:0]        bcd_high;
        logic               negative;
        b2bcdr_pkg::count_t digit_count;
        b2bcdr_pkg::count_t trailing_zeros;
        logic               length_grew;
    } bcd_word_t;

    class bcd_rounding_checker;
        bcd_word_t pending_words[$];
        int        failures;

        function bcd_word_t predict_rounded_bcd(b2bcdr_pkg::value_t value, logic is_signed,
                                                logic [4:0] drop);
            b2bcdr_pkg::digit_t dig [b2bcdr_pkg::NumDigits];
            b2bcdr_pkg::value_t mag;
            logic               neg_in;
            logic               up;
            int                 len0;
            int                 len1;
            int                 tz;
            bcd_word_t          r;
            neg_in = is_signed && value[63];
            mag    = neg_in ? -value : value;
            for (int i = 0; i < b2bcdr_pkg::NumDigits; i++) begin
                dig[i] = b2bcdr_pkg::digit_t'(mag % 10);
                mag    = mag / 10;
            end
            len0 = 0;
            for (int i = 0; i < b2bcdr_pkg::NumDigits; i++) begin
                if (dig[i] != 0) len0 = i + 1;
            end
            if (drop != 0) begin
                if (int'(drop) > len0) begin
                    for (int i = 0; i < b2bcdr_pkg::NumDigits; i++) dig[i] = '0;
                end else begin
                    up = dig[drop - 1] >= 5;
                    for (int i = 0; i < int'(drop); i++) dig[i] = '0;
                    if (up) begin
                        for (int i = int'(drop); i < b2bcdr_pkg::NumDigits; i++) begin
                            if (dig[i] == 9) begin
                                dig[i] = '0;
                            end else begin
                                dig[i] = dig[i] + 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            len1 = 0;
            for (int i = 0; i < b2bcdr_pkg::NumDigits; i++) begin
                if (dig[i] != 0) len1 = i + 1;
            end
            tz = 0;
            if (len1 != 0) begin
                while (tz < b2bcdr_pkg::NumDigits && dig[tz] == 0) tz++;
            end
            for (int i = 0; i < 16; i++) r.bcd_low[4*i +: 4] = dig[i];
            for (int i = 16; i < b2bcdr_pkg::NumDigits; i++) r.bcd_high[4*(i-16) +: 4] = dig[i];
            r.negative       = neg_in && len1 != 0;
            r.digit_count    = b2bcdr_pkg::count_t'(len1);
            r.trailing_zeros = b2bcdr_pkg::count_t'(tz);
            r.length_grew    = drop != 0 && int'(drop) <= len0 && len1 > len0;
            return r;
        endfunction

        function void note_conversion(b2bcdr_pkg::value_t value, logic is_signed,
                                      logic [4:0] drop);
            pending_words.push_back(predict_rounded_bcd(value, is_signed, drop));
        endfunction

        function void report(string what, bcd_word_t want, bcd_word_t got);
            failures++;
            if (failures <= 10) begin
                $display("%s: exp low=%h high=%h neg=%0d cnt=%0d tz=%0d grew=%0d",
                         what, want.bcd_low, want.bcd_high, want.negative,
                         want.digit_count, want.trailing_zeros, want.length_grew);
                $display("    act low=%h high=%h neg=%0d cnt=%0d tz=%0d grew=%0d",
                         got.bcd_low, got.bcd_high, got.negative,
                         got.digit_count, got.trailing_zeros, got.length_grew);
            end
        endfunction

        function void check_conversion(logic [b2bcdr_pkg::MDataW-1:0] data,
                                       logic [b2bcdr_pkg::MUserW-1:0] user);
            bcd_word_t got;
            bcd_word_t want;
            got.bcd_low        = data[63:0];
            got.bcd_high       = data[79:64];
            got.digit_count    = data[84:80];
            got.trailing_zeros = data[89:85];
            got.negative       = user[0];
            got.length_grew    = user[1];
            if (pending_words.size() == 0) begin
                report("unexpected result word", got, got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) report("result word mismatch", want, got);
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void close();
            while (pending_words.size() != 0) begin
                report("missing result word", pending_words[0], pending_words[0]);
                void'(pending_words.pop_front());
            end
        endfunction
    endclass

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [b2bcdr_pkg::SDataW-1:0]     s_tdata  = '0;
    logic [b2bcdr_pkg::SUserW-1:0]     s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [b2bcdr_pkg::MDataW-1:0]     m_tdata;
    logic [b2bcdr_pkg::MUserW-1:0]     m_tuser;

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;

    bcd_rounding_checker sb = new();

    binary_to_bcd_with_rounding u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= receiver_stall_pct == 0 || $urandom_range(99) >= receiver_stall_pct;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_conversion(s_tdata[63:0], s_tuser[0], s_tdata[68:64]);
            end
            if (m_tvalid && m_tready) sb.check_conversion(m_tdata, m_tuser);
        end
    end

    task automatic send_word(b2bcdr_pkg::value_t value, logic is_signed, logic [4:0] drop);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, drop, value};
        s_tuser  <= is_signed;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic b2bcdr_pkg::value_t shaped_value();
        b2bcdr_pkg::value_t v;
        int                 n;
        int                 d;
        case ($urandom_range(9))
            0, 1: v = {$urandom, $urandom};
            2: v = $urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            default: begin
                v = '0;
                n = $urandom_range(1, b2bcdr_pkg::NumDigits);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(7))
                        0: d = 9;
                        1: d = 5;
                        2: d = 4;
                        3: d = 0;
                        default: d = $urandom_range(9);
                    endcase
                    v = v * 10 + b2bcdr_pkg::value_t'(d);
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_random_word();
        b2bcdr_pkg::value_t v;
        logic               sgn;
        logic [4:0]         drop;
        v   = shaped_value();
        sgn = 1'($urandom_range(1));
        if (sgn && $urandom_range(1)) v = -v;
        drop = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(21));
        send_word(v, sgn, drop);
    endtask

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(64'd0, 1'b0, 5'd0);
        send_word(64'd0, 1'b1, 5'd31);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd19);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd20);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0);
        send_word(64'h8000_0000_0000_0000, 1'b1, 5'd0);
        send_word(64'h8000_0000_0000_0000, 1'b1, 5'd3);
        send_word(64'h8000_0000_0000_0000, 1'b0, 5'd16);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd17);
        send_word(64'd999999, 1'b0, 5'd1);
        send_word(64'd95, 1'b0, 5'd1);
        send_word(64'd5, 1'b0, 5'd1);
        send_word(64'd4, 1'b0, 5'd1);
        send_word(64'd5, 1'b0, 5'd2);
        send_word(-64'd4, 1'b1, 5'd1);
        send_word(-64'd96, 1'b1, 5'd1);
        send_word(64'd9999999999999999999, 1'b0, 5'd1);
        send_word(64'd9999999999999999999, 1'b0, 5'd19);
        send_word(64'd1234567890123456789, 1'b0, 5'd21);
        send_word(64'd1000, 1'b0, 5'd0);
        send_word(64'd123456, 1'b1, 5'd15);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            repeat (170) send_random_word();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        sb.close();
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/b2bcdr_pkg.sv
sv/binary_to_bcd_with_rounding.sv
verif/binary_to_bcd_with_rounding_tb.sv
